/* hw/rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(expr))) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* hw/rtl/mavg_pkg.sv */
// shared types and constants of the moving average / ema filter
package mavg_pkg;

  // payload and register widths
  localparam int SampleW  = 24;
  localparam int ChanW    = 3;
  localparam int WinW     = 5;
  localparam int SmoothW  = 8;
  localparam int DzW      = 23;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 23;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWindow   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSmooth   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadZone = 2'd2;

  // register reset values
  localparam logic [WinW-1:0]    WinReset    = 5'd1;
  localparam logic [SmoothW-1:0] SmoothReset = 8'd1;
  localparam logic [DzW-1:0]     DzReset     = 23'd65536;

  // default sizes
  localparam int DefChannels = 6;
  localparam int DefMaxOrder = 16;

  // quotient bits produced per divider cycle
  localparam int DivStep = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_AVG_DIV,
    ST_EMA_GO,
    ST_EMA_DIV,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic ring_wr;
    logic sum_en;
    logic avg_go;
    logic avg_take;
    logic ema_go;
    logic ema_take;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic chan_ok;
    logic clear_last;
    logic sum_done;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/mavg_ram.sv */
// generic single write port, single read port ram with registered read
module mavg_ram #(
  parameter int Width = 24,
  parameter int Depth = 96,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mavg_div.sv */
// unsigned restoring divider, a few quotient bits per cycle
module mavg_div #(
  parameter int DividendW = 30,
  parameter int DivisorW  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);
  import mavg_pkg::*;

  localparam int Iter = DividendW / DivStep;
  localparam int CntW = (Iter > 1) ? $clog2(Iter) : 1;

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DivisorW:0]    rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q;

  // DivStep dependent shift-and-subtract steps
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DivStep; i++) begin
      rem_d = {rem_d[DivisorW-1:0], quo_d[DividendW-1]};
      quo_d = {quo_d[DividendW-2:0], 1'b0};
      if (rem_d >= {1'b0, dvs_q}) begin
        rem_d    = rem_d - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Iter - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/mavg_ctrl.sv */
// sequencing controller of the filter
module mavg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mavg_pkg::stat_t stat_i,
  output mavg_pkg::cmd_t  cmd_o
);
  import mavg_pkg::*;

  state_e state_q, state_d;

  // state register, reset starts the ring clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.chan_ok) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.ring_wr = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (stat_i.sum_done) begin
          cmd_o.avg_go = 1'b1;
          state_d      = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = ST_EMA_GO;
        end
      end
      ST_EMA_GO: begin
        cmd_o.ema_go = 1'b1;
        state_d      = ST_EMA_DIV;
      end
      ST_EMA_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.ema_take = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/mavg_dp.sv */
// datapath: config registers, rings, accumulator, shared divider, output register
module mavg_dp #(
  parameter int CHANNELS  = mavg_pkg::DefChannels,
  parameter int MAX_ORDER = mavg_pkg::DefMaxOrder
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mavg_pkg::cmd_t                       cmd_i,
  output mavg_pkg::stat_t                      stat_o,
  input  logic                                 cfg_valid_i,
  input  logic [mavg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mavg_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [mavg_pkg::ChanW-1:0]           channel_i,
  input  logic signed [mavg_pkg::SampleW-1:0]  sample_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [mavg_pkg::ChanW-1:0]           out_channel_o,
  output logic signed [mavg_pkg::SampleW-1:0]  window_average_o,
  output logic signed [mavg_pkg::SampleW-1:0]  filtered_o
);
  import mavg_pkg::*;

  localparam int Depth  = CHANNELS * MAX_ORDER;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IdxW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int LenW   = $clog2(MAX_ORDER + 1);
  localparam int SumW   = SampleW + LenW;
  localparam int MagW   = (SumW > DzW) ? SumW : DzW;
  localparam int EmaW   = SampleW + 2;
  localparam int DivRaw = (SumW > EmaW) ? SumW : EmaW;
  localparam int DivW   = ((DivRaw + DivStep - 1) / DivStep) * DivStep;
  localparam int DvW    = (LenW > SmoothW + 1) ? LenW : SmoothW + 1;

  // configuration registers
  logic [WinW-1:0]    cfg_win_q;
  logic [SmoothW-1:0] cfg_smooth_q;
  logic [DzW-1:0]     cfg_dz_q;

  // item registers
  logic [ChW-1:0]             ch_q;
  logic signed [SampleW-1:0]  sample_q;
  logic [IdxW-1:0]            ptr_q [CHANNELS];
  logic signed [SampleW-1:0]  prev_q [CHANNELS];
  logic [AddrW-1:0]           clr_q;
  logic [LenW-1:0]            rd_idx_q;
  logic                       rvalid_q;
  logic signed [SumW-1:0]     acc_q;
  logic signed [SampleW-1:0]  avg_q, ema_q;
  logic                       neg_q;

  // output register
  logic                       out_valid_q;
  logic [ChanW-1:0]           out_ch_q;
  logic signed [SampleW-1:0]  out_avg_q, out_ema_q;

  // combinational values
  logic [LenW-1:0]            len;
  logic [SmoothW-1:0]         nsm;
  logic [IdxW-1:0]            ptr_cur, pos, ptr_nxt;
  logic [LenW-1:0]            pos1;
  logic [AddrW-1:0]           base;
  logic                       rd_issue;
  logic [SumW-1:0]            acc_mag;
  logic                       dz_hit;
  logic signed [EmaW-1:0]     ema_diff;
  logic [EmaW-1:0]            ema_mag;
  logic signed [DivW:0]       q_s;
  logic signed [EmaW-1:0]     ema_sum;

  // ram and divider hookup
  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [SampleW-1:0]         ram_wdata, ram_rdata;
  logic                       div_start, div_busy, div_done;
  logic [DivW-1:0]            div_dividend, div_q;
  logic [DvW-1:0]             div_divisor;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q    <= WinReset;
      cfg_smooth_q <= SmoothReset;
      cfg_dz_q     <= DzReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWindow:   cfg_win_q    <= cfg_data_i[WinW-1:0];
        CfgSmooth:   cfg_smooth_q <= cfg_data_i[SmoothW-1:0];
        CfgDeadZone: cfg_dz_q     <= cfg_data_i[DzW-1:0];
        default: ;
      endcase
    end
  end

  // clamp window length to 1..MAX_ORDER and the period to at least 1
  always_comb begin
    if (cfg_win_q == '0) begin
      len = LenW'(1);
    end else if (32'(cfg_win_q) > MAX_ORDER) begin
      len = LenW'(MAX_ORDER);
    end else begin
      len = LenW'(cfg_win_q);
    end
    nsm = (cfg_smooth_q == '0) ? SmoothW'(1) : cfg_smooth_q;
  end

  // ring position of the new sample and the advanced pointer
  assign ptr_cur = ptr_q[ch_q];
  assign pos     = (LenW'(ptr_cur) >= len) ? '0 : ptr_cur;
  assign pos1    = LenW'(pos) + LenW'(1);
  assign ptr_nxt = (pos1 >= len) ? '0 : IdxW'(pos1);
  assign base    = AddrW'(ch_q) * AddrW'(MAX_ORDER);

  // ram port selection
  assign ram_we    = cmd_i.clear | cmd_i.ring_wr;
  assign ram_waddr = cmd_i.clear ? clr_q : base + AddrW'(pos);
  assign ram_wdata = cmd_i.clear ? '0 : sample_q;
  assign ram_raddr = base + AddrW'(rd_idx_q[IdxW-1:0]);
  assign rd_issue  = cmd_i.sum_en && (rd_idx_q < len);

  mavg_ram #(
    .Width (SampleW),
    .Depth (Depth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // per channel pointer and last ema value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        prev_q[c] <= '0;
      end
    end else begin
      if (cmd_i.ring_wr) begin
        ptr_q[ch_q] <= ptr_nxt;
      end
      if (cmd_i.ema_take) begin
        prev_q[ch_q] <= SampleW'(ema_sum);
      end
    end
  end

  // read sequencing over the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_issue;
      if (cmd_i.ring_wr) begin
        rd_idx_q <= '0;
      end else if (rd_issue) begin
        rd_idx_q <= rd_idx_q + LenW'(1);
      end
    end
  end

  // beat capture and accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q     <= ChW'(channel_i);
      sample_q <= sample_i;
    end
    if (cmd_i.ring_wr) begin
      acc_q <= '0;
    end else if (rvalid_q) begin
      acc_q <= acc_q + SumW'($signed(ram_rdata));
    end
  end

  // dead zone check and ema difference
  assign acc_mag  = acc_q[SumW-1] ? SumW'(-acc_q) : SumW'(acc_q);
  assign dz_hit   = MagW'(acc_mag) < MagW'(cfg_dz_q);
  assign ema_diff = (EmaW'(avg_q) - EmaW'(prev_q[ch_q])) <<< 1;
  assign ema_mag  = ema_diff[EmaW-1] ? EmaW'(-ema_diff) : EmaW'(ema_diff);

  // shared divider operands
  assign div_start    = cmd_i.avg_go | cmd_i.ema_go;
  assign div_dividend = cmd_i.avg_go ? (dz_hit ? '0 : DivW'(acc_mag)) : DivW'(ema_mag);
  assign div_divisor  = cmd_i.avg_go ? DvW'(len) : DvW'(nsm) + DvW'(1);

  mavg_div #(
    .DividendW (DivW),
    .DivisorW  (DvW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // signed quotient, truncated toward zero
  assign q_s     = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign ema_sum = EmaW'(prev_q[ch_q]) + EmaW'(q_s);

  // average and ema results
  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_go) begin
      neg_q <= acc_q[SumW-1];
    end else if (cmd_i.ema_go) begin
      neg_q <= ema_diff[EmaW-1];
    end
    if (cmd_i.avg_take) begin
      avg_q <= SampleW'(q_s);
    end
    if (cmd_i.ema_take) begin
      ema_q <= SampleW'(ema_sum);
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch_q  <= ChanW'(ch_q);
      out_avg_q <= avg_q;
      out_ema_q <= ema_q;
    end
  end

  // status back to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.chan_ok    = 32'(channel_i) < CHANNELS;
    stat_o.clear_last = clr_q == AddrW'(Depth - 1);
    stat_o.sum_done   = (rd_idx_q == len) && !rvalid_q;
    stat_o.div_busy   = div_busy;
    stat_o.div_done   = div_done;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_ch_q;
  assign window_average_o = out_avg_q;
  assign filtered_o       = out_ema_q;

endmodule

/* hw/rtl/moving_average_deadzone_ema.sv */
// Six-channel accelerometer smoother: dead-zoned moving average then ema.
// Input channel: in_valid_i / in_stall_o carry one beat of channel_i and
//   sample_i (signed Q8.16 g). A beat naming a channel at or above CHANNELS
//   is taken and dropped without a result.
// Output channel: out_valid_o / out_stall_i carry one beat per input beat
//   on a channel below CHANNELS, with out_channel_o, window_average_o and filtered_o.
// Config channel: cfg_valid_i / cfg_ready_o write cfg_data_i to register
//   cfg_index_i (0 window length, 1 smoothing period, 2 dead zone); ready is
//   always high and writes belong to idle periods.
// One item is worked on at a time. From acceptance to the result in the
//   output register the work is one ring read per window entry plus two
//   passes through the shared two-bits-per-cycle divider; the next beat is
//   taken the cycle after the result is loaded into the output register.
// The output register holds a finished result while the next beat is taken;
//   if it is still stalled when the next result is ready, the block waits
//   and keeps in_stall_o high.
// After reset the rings are swept to zero, one entry a cycle, over all
//   CHANNELS*MAX_ORDER entries (96 by default); in_stall_o stays high meanwhile.
`include "assert_macros.svh"

module moving_average_deadzone_ema #(
  parameter int CHANNELS  = mavg_pkg::DefChannels,
  parameter int MAX_ORDER = mavg_pkg::DefMaxOrder
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mavg_pkg::ChanW-1:0]          channel_i,
  input  logic signed [mavg_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mavg_pkg::ChanW-1:0]          out_channel_o,
  output logic signed [mavg_pkg::SampleW-1:0] window_average_o,
  output logic signed [mavg_pkg::SampleW-1:0] filtered_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mavg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mavg_pkg::CfgDataW-1:0]       cfg_data_i
);
  import mavg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mavg_dp #(
    .CHANNELS  (CHANNELS),
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .channel_i        (channel_i),
    .sample_i         (sample_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_channel_o    (out_channel_o),
    .window_average_o (window_average_o),
    .filtered_o       (filtered_o)
  );

  // result register is only loaded when its beat is gone or leaving
  `ASSERT_CLK(a_out_load_free, clk_i, rst_ni, cmd.out_load |-> !(out_valid_o && out_stall_i))
  // a new result beat appears only after a load from the controller
  `ASSERT_CLK(a_out_rise_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.out_load))
  // the divider is never restarted mid-division
  `ASSERT_NEVER(a_div_restart, clk_i, rst_ni, (cmd.avg_go || cmd.ema_go) && stat.div_busy)
  // no input beat is taken while a division runs
  `ASSERT_CLK(a_stall_busy, clk_i, rst_ni, stat.div_busy |-> in_stall_o)

endmodule

/* sim/moving_average_deadzone_ema_checker.sv */
`timescale 1ns / 1ps
// passive checker of the smoother: predicts every result beat and compares it
module moving_average_deadzone_ema_checker #(
  parameter int CHANNELS  = mavg_pkg::DefChannels,
  parameter int MAX_ORDER = mavg_pkg::DefMaxOrder
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [mavg_pkg::ChanW-1:0]          channel_i,
  input  logic signed [mavg_pkg::SampleW-1:0] sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [mavg_pkg::ChanW-1:0]          out_channel_i,
  input  logic signed [mavg_pkg::SampleW-1:0] window_average_i,
  input  logic signed [mavg_pkg::SampleW-1:0] filtered_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mavg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mavg_pkg::CfgDataW-1:0]       cfg_data_i,
  output int unsigned                         awaiting_o,
  output int unsigned                         errors_o,
  output int unsigned                         checked_o
);
  import mavg_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0]          chan;
    logic signed [SampleW-1:0] avg;
    logic signed [SampleW-1:0] ema;
  } smooth_result_t;

  // shadow of the filter state and registers
  logic signed [SampleW-1:0] ring_q [CHANNELS][MAX_ORDER];
  int unsigned               ring_head [CHANNELS];
  logic signed [SampleW-1:0] ema_last [CHANNELS];
  logic [WinW-1:0]           win_len;
  logic [SmoothW-1:0]        ema_period;
  logic [DzW-1:0]            dz_limit;

  smooth_result_t pending_results [$];
  int unsigned    err_total;
  int unsigned    seen_total;

  // one sample through the ring, the dead zone and the ema
  function automatic smooth_result_t smooth_sample(logic [ChanW-1:0] ch,
                                                   logic signed [SampleW-1:0] smp);
    int unsigned    len;
    int unsigned    per;
    int unsigned    pos;
    int unsigned    k;
    longint         total;
    longint         mag;
    longint         avg;
    longint         prev;
    longint         ema;
    smooth_result_t res;
    len = (win_len == 0) ? 1 : ((win_len > MAX_ORDER) ? MAX_ORDER : win_len);
    per = (ema_period == 0) ? 1 : ema_period;
    // a pointer left past a shortened window restarts at entry zero
    pos = ring_head[ch];
    if (pos >= len) pos = 0;
    ring_q[ch][pos] = smp;
    pos++;
    if (pos >= len) pos = 0;
    ring_head[ch] = pos;
    total = 0;
    for (k = 0; k < len; k++) total += ring_q[ch][k];
    mag = (total < 0) ? -total : total;
    if (mag < longint'(dz_limit)) avg = 0;
    else avg = total / longint'(len);
    prev = ema_last[ch];
    ema = prev + (2 * (avg - prev)) / (longint'(per) + 1);
    ema_last[ch] = ema[SampleW-1:0];
    res.chan = ch;
    res.avg  = avg[SampleW-1:0];
    res.ema  = ema[SampleW-1:0];
    return res;
  endfunction

  task automatic report_field(input string field, input logic [ChanW-1:0] ch,
                              input logic signed [SampleW-1:0] want_v,
                              input logic signed [SampleW-1:0] got_v);
    if (want_v !== got_v) begin
      err_total++;
      $display("%0t: ch %0d %s expected %0d got %0d", $time, ch, field,
               $signed(want_v), $signed(got_v));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_result_t want;
    if (!rst_ni) begin
      win_len    = WinReset;
      ema_period = SmoothReset;
      dz_limit   = DzReset;
      for (int c = 0; c < CHANNELS; c++) begin
        ring_head[c] = 0;
        ema_last[c]  = '0;
        for (int e = 0; e < MAX_ORDER; e++) ring_q[c][e] = '0;
      end
      pending_results.delete();
      err_total  = 0;
      seen_total = 0;
      awaiting_o <= 0;
      errors_o   <= 0;
      checked_o  <= 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          err_total++;
          $display("%0t: result beat with nothing expected, ch %0d avg %0d ema %0d",
                   $time, out_channel_i, window_average_i, filtered_i);
        end else begin
          want = pending_results.pop_front();
          seen_total++;
          report_field("out_channel", want.chan, SampleW'(want.chan),
                       SampleW'(out_channel_i));
          report_field("window_average", want.chan, want.avg, window_average_i);
          report_field("filtered", want.chan, want.ema, filtered_i);
        end
      end
      // register beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgWindow:   win_len    = cfg_data_i[WinW-1:0];
          CfgSmooth:   ema_period = cfg_data_i[SmoothW-1:0];
          CfgDeadZone: dz_limit   = cfg_data_i[DzW-1:0];
          default: ;
        endcase
      end
      // sample beat, unused channels are dropped silently
      if (in_valid_i && !in_stall_i && channel_i < CHANNELS) begin
        pending_results.push_back(smooth_sample(channel_i, sample_i));
      end
      awaiting_o <= pending_results.size();
      errors_o   <= err_total;
      checked_o  <= seen_total;
    end
  end

endmodule

/* sim/moving_average_deadzone_ema_tb.sv */
`timescale 1ns / 1ps
// regression top of the smoother: clock, reset, stimulus, handshake pacing and verdict
module moving_average_deadzone_ema_tb;
  import mavg_pkg::*;

  localparam int Channels     = DefChannels;
  localparam int MaxOrder     = DefMaxOrder;
  localparam int SettleCycles = 80;
  localparam int CycleLimit   = 800000;
  localparam int RandomPhases = 12;
  localparam int PhaseBeats   = 125;
  localparam logic [CfgIdxW-1:0]        CfgSpare  = 2'd3;
  localparam logic signed [SampleW-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMin = 24'sh800000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [ChanW-1:0]          channel_i   = '0;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ChanW-1:0]          out_channel_o;
  logic signed [SampleW-1:0] window_average_o;
  logic signed [SampleW-1:0] filtered_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i  = '0;

  int unsigned awaiting;
  int unsigned mismatches;
  int unsigned compared;
  int unsigned cycle_cnt  = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_drop = 0;
  int unsigned settings   = 0;
  bit          no_idle    = 1'b0;
  int          level [Channels];

  moving_average_deadzone_ema u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .channel_i        (channel_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .window_average_o (window_average_o),
    .filtered_o       (filtered_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  moving_average_deadzone_ema_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .channel_i        (channel_i),
    .sample_i         (sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_i    (out_channel_o),
    .window_average_i (window_average_o),
    .filtered_i       (filtered_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .awaiting_o       (awaiting),
    .errors_o         (mismatches),
    .checked_o        (compared)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_cnt, awaiting);
      $display("moving_average_deadzone_ema regression: fail");
      $finish;
    end
  end

  // result side: random stall before every beat
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one sample beat after a random gap, valid stays high across back-to-back beats
  task automatic send_sample(input logic [ChanW-1:0] ch, input logic signed [SampleW-1:0] smp);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    if (ch < Channels) beats_sent++;
    else beats_drop++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // new register setting, only called while the filter is idle
  task automatic program_filter(input logic [WinW-1:0] win, input logic [SmoothW-1:0] per,
                                input logic [DzW-1:0] dz, input bit spare);
    if (spare) write_reg(CfgSpare, CfgDataW'($urandom()));
    write_reg(CfgWindow, CfgDataW'(win));
    write_reg(CfgSmooth, CfgDataW'(per));
    write_reg(CfgDeadZone, CfgDataW'(dz));
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // wait for every predicted result, then let a dropped beat finish too
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [WinW-1:0]           win;
    logic [SmoothW-1:0]        per;
    logic [DzW-1:0]            dz;
    logic [ChanW-1:0]          ch;
    logic signed [SampleW-1:0] smp;
    logic [31:0]               raw;
    int                        mix;
    int unsigned               sent;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: extremes, dead zone edge, unused channels
    send_sample(3'd0, '0);
    send_sample(3'd0, SampleMax);
    send_sample(3'd5, SampleMin);
    send_sample(3'd1, 24'sd65535);
    send_sample(3'd1, -24'sd65536);
    send_sample(3'd6, SampleMax);
    send_sample(3'd7, SampleMin);
    drain();

    // full window, slowest ema, no dead zone
    program_filter(5'd16, 8'd255, 23'd0, 1'b1);
    send_sample(3'd2, SampleMax);
    send_sample(3'd2, SampleMax);
    send_sample(3'd2, SampleMax);
    send_sample(3'd2, SampleMin);
    send_sample(3'd2, SampleMin);
    send_sample(3'd4, 24'sd1);
    drain();

    // window shortened below the pointer, period zero, widest dead zone
    program_filter(5'd3, 8'd0, 23'h7FFFFF, 1'b0);
    send_sample(3'd2, SampleMin);
    send_sample(3'd2, SampleMax);
    send_sample(3'd3, -24'sd1);
    drain();

    // oversized window acts as full, stale entries count again
    program_filter(5'd31, 8'd2, 23'd1, 1'b0);
    send_sample(3'd2, '0);
    send_sample(3'd0, -24'sd1);
    send_sample(3'd0, 24'sd1);
    drain();

    // zero window acts as one
    program_filter(5'd0, 8'd1, DzReset, 1'b0);
    send_sample(3'd2, 24'sd12345);
    send_sample(3'd5, SampleMax);
    drain();

    // random phases, each with its own setting and resting levels
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 4))
        0:       win = 5'd1;
        1:       win = 5'd16;
        2:       win = $urandom_range(0, 31);
        default: win = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 4))
        0:       per = 8'd0;
        1:       per = 8'd255;
        2:       per = 8'd1;
        default: per = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 4))
        0:       dz = 23'd0;
        1:       dz = 23'h7FFFFF;
        2:       dz = $urandom();
        default: dz = $urandom_range(0, 262144);
      endcase
      program_filter(win, per, dz, p == RandomPhases / 2);
      for (int c = 0; c < Channels; c++) begin
        if ($urandom_range(0, 1) == 0) level[c] = int'($urandom_range(0, 8388607)) - 4194304;
        else level[c] = int'($urandom_range(0, 131072)) - 65536;
      end
      no_idle = (p % 4 == 3);
      sent = 0;
      while (sent < PhaseBeats) begin
        if ($urandom_range(0, 19) == 0) ch = $urandom_range(6, 7);
        else ch = $urandom_range(0, Channels - 1);
        raw = $urandom();
        mix = (ch < Channels) ? level[ch] : 0;
        // mostly a noisy resting level, with extremes and full-range values mixed in
        case ($urandom_range(0, 9))
          0:       smp = SampleMax;
          1:       smp = SampleMin;
          2, 3, 4: smp = raw[SampleW-1:0];
          5, 6: begin
            mix = mix + int'($urandom_range(0, 2048)) - 1024;
            smp = mix[SampleW-1:0];
          end
          default: begin
            mix = mix + int'($urandom_range(0, 32768)) - 16384;
            smp = mix[SampleW-1:0];
          end
        endcase
        send_sample(ch, smp);
        if (ch < Channels) sent++;
      end
      drain();
    end

    $display("ran %0d samples on live channels and %0d on unused ones, %0d results compared",
             beats_sent, beats_drop, compared);
    $display("used %0d register settings, with random input and output stalls", settings);
    if (mismatches == 0 && awaiting == 0) begin
      $display("moving_average_deadzone_ema regression: pass");
    end else begin
      $display("moving_average_deadzone_ema regression: fail");
    end
    $finish;
  end

endmodule
